// ===== sv/lsti_pkg.sv =====
// lsti_pkg: types, constants and helpers for the looping sample table interpolator
// no dependencies
package lsti_pkg;

    localparam int TableDepth = 1024;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int CountW     = IdxW + 1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
    localparam logic [1:0] REG_SAMPLE_RATE  = 2'd1;
    localparam logic [1:0] REG_START_TIME   = 2'd2;
    localparam logic [1:0] REG_LOOP_ENABLE  = 2'd3;

    localparam logic [31:0] RATE_RESET = 32'd7864320;

    typedef struct packed {
        logic               opcode;
        logic [9:0]         entry_index;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic signed [31:0] query_time;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_x;
        logic signed [31:0] result_y;
        logic signed [31:0] result_z;
        logic               table_empty;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } sample_t;

    typedef struct packed {
        logic [CountW-1:0] count;
        logic [31:0]       rate;
        logic [31:0]       start;
        logic              loop_en;
    } cfg_t;

endpackage

// ===== sv/lsti_index.sv =====
// lsti_index: time to table position pipeline (multiply, wrap or clamp)
// depends on lsti_pkg
module lsti_index (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic                         in_query,
    input  logic signed [31:0]           in_time,
    input  lsti_pkg::cfg_t               cfg,
    output logic                         out_valid,
    output logic                         out_query,
    output logic                         out_empty,
    output logic [lsti_pkg::IdxW-1:0]    out_i,
    output logic [lsti_pkg::IdxW-1:0]    out_inext,
    output logic [15:0]                  out_frac
);
    import lsti_pkg::*;

    // stage 1: delta, clip count, two 32x16 partial products
    logic              v1_reg, q1_reg, before1_reg, empty1_reg;
    logic [CountW-1:0] cnt1_reg;
    logic [47:0]       p0_reg, p1_reg;
    // stage 2: sum to 64-bit position
    logic              v2_reg, q2_reg, before2_reg, empty2_reg;
    logic [CountW-1:0] cnt2_reg;
    logic [31:0]       ip2_reg;
    logic [15:0]       fr2_reg;
    // stages 3 to 6: ipart % count by a 32-step restoring pass, 8 steps per stage
    localparam int ModStages = 4;
    localparam int StepsPer  = 32 / ModStages;

    logic signed [32:0] delta;
    logic [CountW-1:0]  cnt_clip;
    logic [63:0]        pos;

    // start time is signed, so both operands are sign-extended
    assign delta    = 33'(in_time) - 33'($signed(cfg.start));
    assign cnt_clip = (cfg.count > CountW'(TableDepth)) ? CountW'(TableDepth) : cfg.count;
    assign pos      = {16'd0, p0_reg} + {p1_reg, 16'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_reg      <= in_query;
            before1_reg <= delta[32];
            empty1_reg  <= (cnt_clip == '0);
            cnt1_reg    <= cnt_clip;
            p0_reg      <= delta[31:0] * cfg.rate[15:0];
            p1_reg      <= delta[31:0] * cfg.rate[31:16];
            q2_reg      <= q1_reg;
            before2_reg <= before1_reg;
            empty2_reg  <= empty1_reg;
            cnt2_reg    <= cnt1_reg;
            ip2_reg     <= pos[63:32];
            fr2_reg     <= pos[31:16];
        end
    end

    // restoring remainder pipeline
    logic              mv_reg [ModStages];
    logic              mq_reg [ModStages];
    logic              mb_reg [ModStages];
    logic              me_reg [ModStages];
    logic              ml_reg [ModStages];
    logic [CountW-1:0] mc_reg [ModStages];
    logic [31:0]       mn_reg [ModStages];
    logic [CountW-1:0] mr_reg [ModStages];
    logic [15:0]       mf_reg [ModStages];
    logic [31:0]       mi_reg [ModStages];
    logic              loop_q;

    assign loop_q = cfg.loop_en;

    for (genvar s = 0; s < ModStages; s++)
    begin : g_mod
        logic              pv, pq, pb, pe, pl;
        logic [CountW-1:0] pc, pr_in;
        logic [31:0]       pn, pi;
        logic [15:0]       pf;
        logic [CountW-1:0] r_out;
        logic [31:0]       n_out;

        if (s == 0)
        begin : g_first
            assign pv = v2_reg; assign pq = q2_reg; assign pb = before2_reg;
            assign pe = empty2_reg; assign pl = loop_q; assign pc = cnt2_reg;
            assign pn = ip2_reg; assign pr_in = '0; assign pf = fr2_reg;
            assign pi = ip2_reg;
        end
        else
        begin : g_rest
            assign pv = mv_reg[s-1]; assign pq = mq_reg[s-1]; assign pb = mb_reg[s-1];
            assign pe = me_reg[s-1]; assign pl = ml_reg[s-1]; assign pc = mc_reg[s-1];
            assign pn = mn_reg[s-1]; assign pr_in = mr_reg[s-1]; assign pf = mf_reg[s-1];
            assign pi = mi_reg[s-1];
        end

        always_comb
        begin
            logic [CountW:0] t;
            r_out = pr_in;
            n_out = pn;
            for (int k = 0; k < StepsPer; k++)
            begin
                t = {r_out, n_out[31]};
                n_out = {n_out[30:0], 1'b0};
                if (t >= {1'b0, pc})
                    t = t - {1'b0, pc};
                r_out = t[CountW-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                mv_reg[s] <= 1'b0;
            else if (adv)
                mv_reg[s] <= pv;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mq_reg[s] <= pq; mb_reg[s] <= pb; me_reg[s] <= pe; ml_reg[s] <= pl;
                mc_reg[s] <= pc; mn_reg[s] <= n_out; mr_reg[s] <= r_out;
                mf_reg[s] <= pf; mi_reg[s] <= pi;
            end
        end
    end

    // final selection
    localparam int L = ModStages - 1;
    logic [CountW-1:0] last, i_sel, n_sel;
    logic              i_ovf;

    always_comb
    begin
        last  = mc_reg[L] - CountW'(1);
        i_ovf = (mi_reg[L] > 32'(last));
        if (mb_reg[L])
        begin
            i_sel = '0;
            n_sel = '0;
        end
        else if (ml_reg[L])
        begin
            i_sel = mr_reg[L];
            n_sel = (mr_reg[L] == last) ? '0 : mr_reg[L] + CountW'(1);
        end
        else
        begin
            i_sel = i_ovf ? last : mi_reg[L][CountW-1:0];
            n_sel = (i_sel >= last) ? last : i_sel + CountW'(1);
        end
    end

    assign out_valid = mv_reg[L];
    assign out_query = mq_reg[L];
    assign out_empty = me_reg[L];
    assign out_i     = i_sel[IdxW-1:0];
    assign out_inext = n_sel[IdxW-1:0];
    assign out_frac  = mb_reg[L] ? 16'd0 : mf_reg[L];
endmodule

// ===== sv/lsti_table.sv =====
// lsti_table: sample memory, one write port, two registered read ports
// depends on lsti_pkg
module lsti_table (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic                      wr_en,
    input  logic [lsti_pkg::IdxW-1:0] wr_addr,
    input  lsti_pkg::sample_t         wr_data,
    input  logic [lsti_pkg::IdxW-1:0] rd_addr_a,
    input  logic [lsti_pkg::IdxW-1:0] rd_addr_b,
    output lsti_pkg::sample_t         rd_data_a,
    output lsti_pkg::sample_t         rd_data_b
);
    import lsti_pkg::*;

    sample_t mem_a [TableDepth];
    sample_t mem_b [TableDepth];

    // two copies give two read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_addr] <= wr_data;
            mem_b[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem_a[rd_addr_a];
            rd_data_b <= mem_b[rd_addr_b];
        end
    end
endmodule

// ===== sv/lsti_blend.sv =====
// lsti_blend: one component of the linear blend, registered product with a combinational sum
// depends on lsti_pkg
module lsti_blend (
    input  logic               clk,
    input  logic               adv,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    input  logic [15:0]        frac,
    output logic signed [31:0] r
);
    import lsti_pkg::*;

    // a*(65536-f) + b*f = a*65536 + (b-a)*f
    logic signed [32:0] diff;
    logic signed [49:0] prod_reg;
    logic signed [31:0] a_reg;
    logic signed [49:0] sum;

    assign diff = 33'(b) - 33'(a);
    assign sum  = prod_reg + {{2{a_reg[31]}}, a_reg, 16'd0};
    assign r    = sum[47:16];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= diff * $signed({1'b0, frac});
            a_reg    <= a;
        end
    end
endmodule

// ===== sv/looping_sample_table_interpolator.sv =====
// looping_sample_table_interpolator: top level, stall-together pipeline with registered output
// depends on lsti_pkg, lsti_index, lsti_table, lsti_blend
// one item per cycle sustained while the output is not stalled
// the pipeline advances whenever the output register is free or being taken
// reset clears control and loads the default configuration; table contents are undefined until written
module looping_sample_table_interpolator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lsti_pkg::in_item_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lsti_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import lsti_pkg::*;

    // write items trail by the depth of the index pipe, so a query reads the
    // table as it stood when the query was accepted
    localparam int WrDelay = 6;

    cfg_t cfg_reg;
    logic adv;

    // the whole pipe moves together; it stalls only when the result is stuck
    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count   <= '0;
            cfg_reg.rate    <= RATE_RESET;
            cfg_reg.start   <= '0;
            cfg_reg.loop_en <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SAMPLE_COUNT: cfg_reg.count   <= cfg_data[CountW-1:0];
                REG_SAMPLE_RATE:  cfg_reg.rate    <= cfg_data;
                REG_START_TIME:   cfg_reg.start   <= cfg_data;
                REG_LOOP_ENABLE:  cfg_reg.loop_en <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // table writes go through a delay line; queries enter the index pipe
    logic acc;
    assign acc = in_valid && in_ready;

    sample_t wr_data;
    assign wr_data = '{x: in_data.value_x, y: in_data.value_y, z: in_data.value_z};

    logic [WrDelay-1:0] wv_reg;
    logic [IdxW-1:0]    wa_reg [WrDelay];
    sample_t            wd_reg [WrDelay];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wv_reg <= '0;
        else if (adv)
            wv_reg <= {wv_reg[WrDelay-2:0], acc && in_data.opcode == OP_WRITE};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wa_reg[0] <= in_data.entry_index[IdxW-1:0];
            wd_reg[0] <= wr_data;
            for (int k = 1; k < WrDelay; k++)
            begin
                wa_reg[k] <= wa_reg[k-1];
                wd_reg[k] <= wd_reg[k-1];
            end
        end
    end

    logic            iv, iq, ie;
    logic [IdxW-1:0] ia, ib;
    logic [15:0]     ifr;

    lsti_index u_index (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (acc && in_data.opcode == OP_QUERY),
        .in_query  (in_data.opcode),
        .in_time   (in_data.query_time),
        .cfg       (cfg_reg),
        .out_valid (iv),
        .out_query (iq),
        .out_empty (ie),
        .out_i     (ia),
        .out_inext (ib),
        .out_frac  (ifr)
    );

    sample_t sa, sb;

    // a write lands only after older queries have read the table
    lsti_table u_table (
        .clk       (clk),
        .rd_en     (adv),
        .wr_en     (adv && wv_reg[WrDelay-1]),
        .wr_addr   (wa_reg[WrDelay-1]),
        .wr_data   (wd_reg[WrDelay-1]),
        .rd_addr_a (ia),
        .rd_addr_b (ib),
        .rd_data_a (sa),
        .rd_data_b (sb)
    );

    // memory read stage
    logic        rv_reg, re_reg;
    logic [15:0] rf_reg;
    // blend stage
    logic        bv_reg, be_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg    <= 1'b0;
            bv_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            rv_reg    <= iv && iq;
            bv_reg    <= rv_reg;
            out_valid <= bv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            re_reg <= ie;
            rf_reg <= ifr;
            be_reg <= re_reg;
        end
    end

    logic signed [31:0] rx, ry, rz;

    lsti_blend u_bx (.clk(clk), .adv(adv), .a(sa.x), .b(sb.x), .frac(rf_reg), .r(rx));
    lsti_blend u_by (.clk(clk), .adv(adv), .a(sa.y), .b(sb.y), .frac(rf_reg), .r(ry));
    lsti_blend u_bz (.clk(clk), .adv(adv), .a(sa.z), .b(sb.z), .frac(rf_reg), .r(rz));

    // output register; empty table forces zero
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data.result_x    <= be_reg ? '0 : rx;
            out_data.result_y    <= be_reg ? '0 : ry;
            out_data.result_z    <= be_reg ? '0 : rz;
            out_data.table_empty <= be_reg;
        end
    end

    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    // empty flag means zero result
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.table_empty |-> out_data.result_x == '0
            && out_data.result_y == '0 && out_data.result_z == '0)
        else $error("empty result not zero");

    // no input taken while stalled
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during stall");
endmodule

// ===== verif/tb_looping_sample_table_interpolator.sv =====
// testbench for the looping sample table interpolator: directed and random items
// predicts every query result from its own table and register copy, checks field by field
// depends on lsti_pkg and looping_sample_table_interpolator
`timescale 1ns / 100ps

module tb_looping_sample_table_interpolator;
    import lsti_pkg::*;

    localparam int LatencyCycles = 8;
    localparam longint CycleLimit = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    // model copy of the table and registers
    sample_t samples[TableDepth];
    bit written[TableDepth];
    logic [10:0] m_count;
    logic [31:0] m_rate;
    logic signed [31:0] m_start;
    logic m_loop;

    out_item_t expected_results[$];
    int error_count = 0;
    longint cycle_count = 0;

    // idling knobs in percent
    int send_gap_pct;
    int recv_stall_pct;
    bit recv_hold;

    looping_sample_table_interpolator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("[looping_sample_table_interpolator] ERROR");
            $finish;
        end
    end

    // floor((a*(65536-f) + b*f) / 65536)
    function automatic logic signed [31:0] lerp_component(logic signed [31:0] a,
                                                          logic signed [31:0] b,
                                                          logic [15:0] f);
        logic signed [63:0] acc;
        acc = 64'(a) * $signed({47'd0, 17'(17'h10000 - f)}) + 64'(b) * $signed({48'd0, f});
        return 32'(acc >>> 16);
    endfunction

    function automatic out_item_t interpolate_query(logic signed [31:0] t);
        out_item_t r;
        logic [10:0] cnt;
        logic [63:0] delta;
        logic [63:0] pos;
        logic [31:0] ipart;
        logic [15:0] frac;
        int unsigned i;
        int unsigned nxt;
        r = '0;
        cnt = (m_count > TableDepth) ? 11'(TableDepth) : m_count;
        if (cnt == 0)
        begin
            r.table_empty = 1'b1;
            return r;
        end
        if (t < m_start)
        begin
            r.result_x = samples[0].x;
            r.result_y = samples[0].y;
            r.result_z = samples[0].z;
            return r;
        end
        // distance from start is unsigned once t is at or after it
        delta = {32'd0, 32'(t - m_start)};
        pos = delta * {32'd0, m_rate};
        ipart = pos[63:32];
        frac = pos[31:16];
        if (m_loop)
        begin
            i = ipart % cnt;
            nxt = (i + 1) % cnt;
        end
        else
        begin
            i = (ipart > cnt - 1) ? cnt - 1 : ipart;
            nxt = (i + 1 > cnt - 1) ? cnt - 1 : i + 1;
        end
        r.result_x = lerp_component(samples[i].x, samples[nxt].x, frac);
        r.result_y = lerp_component(samples[i].y, samples[nxt].y, frac);
        r.result_z = lerp_component(samples[i].z, samples[nxt].z, frac);
        return r;
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        out_item_t exp_item;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result item with no expectation pending");
                error_count++;
            end
            else
            begin
                exp_item = expected_results.pop_front();
                if (out_data.result_x !== exp_item.result_x)
                begin
                    $error("result_x expected %0d actual %0d", exp_item.result_x, out_data.result_x);
                    error_count++;
                end
                if (out_data.result_y !== exp_item.result_y)
                begin
                    $error("result_y expected %0d actual %0d", exp_item.result_y, out_data.result_y);
                    error_count++;
                end
                if (out_data.result_z !== exp_item.result_z)
                begin
                    $error("result_z expected %0d actual %0d", exp_item.result_z, out_data.result_z);
                    error_count++;
                end
                if (out_data.table_empty !== exp_item.table_empty)
                begin
                    $error("table_empty expected %0d actual %0d", exp_item.table_empty,
                           out_data.table_empty);
                    error_count++;
                end
            end
        end
    end

    // hand one item to the block; the model is updated at acceptance
    // valid stays high after acceptance until the next item or an idle stretch
    task automatic send_item(in_item_t it);
        if ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_gap_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (it.opcode == OP_WRITE)
        begin
            samples[it.entry_index] = '{it.value_x, it.value_y, it.value_z};
            written[it.entry_index] = 1'b1;
        end
        else
            expected_results.insert(expected_results.size(), interpolate_query(it.query_time));
    endtask

    task automatic write_sample(int unsigned idx, logic [31:0] x, logic [31:0] y,
                                logic [31:0] z);
        in_item_t it;
        it = '0;
        it.opcode = OP_WRITE;
        it.entry_index = 10'(idx);
        it.value_x = x;
        it.value_y = y;
        it.value_z = z;
        it.query_time = $urandom();
        send_item(it);
    endtask

    task automatic query_at(logic [31:0] t);
        in_item_t it;
        it.opcode = OP_QUERY;
        it.entry_index = 10'($urandom());
        it.value_x = $urandom();
        it.value_y = $urandom();
        it.value_z = $urandom();
        it.query_time = t;
        send_item(it);
    endtask

    // stop sending, wait for all results, then let the pipeline drain a trailing write
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (LatencyCycles + 4) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_SAMPLE_COUNT: m_count = value[10:0];
            REG_SAMPLE_RATE:  m_rate = value;
            REG_START_TIME:   m_start = value;
            REG_LOOP_ENABLE:  m_loop = value[0];
            default:          ;
        endcase
    endtask

    task automatic configure(logic [10:0] cnt, logic [31:0] rate, logic [31:0] start,
                             logic lp);
        drain_results();
        write_register(REG_SAMPLE_COUNT, 32'(cnt));
        write_register(REG_SAMPLE_RATE, rate);
        write_register(REG_START_TIME, start);
        write_register(REG_LOOP_ENABLE, 32'(lp));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(4))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($urandom_range(65536 * 4)) - 32'(65536 * 2);
            default: return $urandom();
        endcase
    endfunction

    // query times near the start, far out, and before it
    function automatic logic [31:0] random_time();
        case ($urandom_range(5))
            0: return m_start - 32'($urandom_range(1, 1000));
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            3: return $urandom();
            default: return m_start + 32'($urandom_range(0, 65536 * 8));
        endcase
    endfunction

    task automatic test_empty_table();
        // count of zero after reset: zero result with the empty flag
        query_at(32'h0);
        query_at(32'h7fffffff);
        query_at(32'h80000000);
    endtask

    task automatic test_directed_edges();
        write_sample(0, 32'h7fffffff, 32'h80000000, 32'h0);
        write_sample(1, 32'h80000000, 32'h7fffffff, 32'hffffffff);
        write_sample(2, 32'h00010000, 32'hffff0000, 32'h12345678);
        write_sample(1023, 32'h55555555, 32'haaaaaaaa, 32'h0000ffff);
        configure(11'd3, 32'h00010000, 32'h0, 1'b0);
        query_at(32'h0);
        query_at(32'h00008000);
        query_at(32'h0000ffff);
        query_at(32'h00018000);
        query_at(32'h7fffffff);  // clamps to last entry
        query_at(32'hffffffff);  // time before start gives entry 0
        configure(11'd3, 32'h00010000, 32'h0, 1'b1);
        query_at(32'h00028000);  // wraps from last entry to entry 0
        query_at(32'h7fffffff);
        // zero rate gives entry 0
        configure(11'd3, 32'h0, 32'h80000000, 1'b1);
        query_at(32'h7fffffff);
        // count above depth acts as depth, largest rate and start at extremes
        // these queries touch only entries 0, 1 and the last one
        configure(11'd2047, 32'hffffffff, 32'h80000000, 1'b0);
        query_at(32'h7fffffff);
        query_at(32'h80000000);
        configure(11'd1024, 32'hffffffff, 32'h7fffffff, 1'b1);
        query_at(32'h7fffffff);
        query_at(32'h7ffffffe);
    endtask

    task automatic fill_table(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            if (!written[i])
                write_sample(i, random_value(), random_value(), random_value());
    endtask

    // random phase: new settings, a fill of the live entries, then queries mixed with writes
    task automatic test_random_phase(int n_items, int gap, int stall);
        logic [10:0] cnt;
        int unsigned idx;
        send_gap_pct = gap;
        recv_stall_pct = stall;
        cnt = ($urandom_range(3) == 0) ? 11'($urandom_range(9, 32)) :
              11'($urandom_range(1, 8));
        configure(cnt, ($urandom_range(1) != 0) ? 32'($urandom_range(1, 65536 * 4)) :
                  $urandom(), random_value(), 1'($urandom()));
        fill_table(32'(cnt));
        for (int k = 0; k < n_items; k++)
        begin
            if ($urandom_range(99) < 20)
            begin
                // writes go to any entry, also beyond the count
                idx = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(15);
                write_sample(idx, random_value(), random_value(), random_value());
            end
            else
                query_at(random_time());
        end
    endtask

    task automatic test_backpressure();
        // receiver holds off while the sender keeps offering queries
        fork
            begin
                recv_hold = 1'b1;
                repeat (60) @(posedge clk);
                recv_hold = 1'b0;
            end
            begin
                send_gap_pct = 0;
                for (int k = 0; k < 30; k++)
                    query_at(random_time());
                in_valid <= 1'b0;
            end
        join
        // sender pauses until every expected result has come
        while (expected_results.size() != 0)
            @(posedge clk);
        for (int k = 0; k < 10; k++)
            query_at(random_time());
    endtask

    initial
    begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_SAMPLE_COUNT;
        cfg_data = '0;
        m_count = '0;
        m_rate = RATE_RESET;
        m_start = '0;
        m_loop = 1'b0;
        for (int i = 0; i < TableDepth; i++)
        begin
            samples[i] = '0;
            written[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_directed_edges();
        test_random_phase(100, 0, 0);
        test_random_phase(100, 54, 0);
        test_random_phase(100, 0, 54);
        test_random_phase(100, 25, 25);
        test_backpressure();

        drain_results();
        if (error_count == 0)
            $display("[looping_sample_table_interpolator] OK");
        else
            $display("[looping_sample_table_interpolator] ERROR");
        $finish;
    end

endmodule
